>>> rtl/core/lmbs_pkg.sv
// Package for the LED matrix bit-plane scanner: geometry defaults, opcodes,
// result kinds, configuration register indexes and reset values.
// No dependencies.
package lmbs_pkg;

	localparam int PLANES_DEF     = 2;
	localparam int COLUMNS_DEF    = 64;
	localparam int ROWS_DEF       = 8;
	localparam int LINE_BYTES_DEF = 16;

	// input opcodes (s_axis_tuser)
	localparam logic [1:0] OP_PLOT  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// result kinds (m_axis_tuser)
	localparam logic [1:0] KIND_BLANK  = 2'd0;
	localparam logic [1:0] KIND_ROW    = 2'd1;
	localparam logic [1:0] KIND_COLUMN = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PERIOD_ZERO = 2'd0;
	localparam logic [1:0] REG_PERIOD_ONE  = 2'd1;
	localparam logic [1:0] REG_DRAW_PLANE  = 2'd2;

	localparam logic [15:0] PERIOD_ZERO_RST = 16'd800;
	localparam logic [15:0] PERIOD_ONE_RST  = 16'd8000;
	localparam logic        DRAW_PLANE_RST  = 1'b1;
	localparam logic [7:0]  LINE_RST        = 8'd255;

endpackage

>>> rtl/core/led_matrix_bitplane_scanner_unit.sv
// A tick's first result word is loaded in the tick state once the output register is free; a
// latch tick then gives one column byte per cycle from the single frame-store read port while
// m_axis_tready does not stall it. Input words are taken only in the idle state; a plot runs a
// red pass, then a green pass if green is painted (the red pass always runs first).
// Reset (arst_n, async, active low) empties the frame store through per-byte valid bits,
// so no clearing pass is needed; a clear word drops all valid bits in the cycle it is taken.
module led_matrix_bitplane_scanner_unit #(
	parameter int PLANES     = lmbs_pkg::PLANES_DEF,
	parameter int COLUMNS    = lmbs_pkg::COLUMNS_DEF,
	parameter int ROWS       = lmbs_pkg::ROWS_DEF,
	parameter int LINE_BYTES = lmbs_pkg::LINE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pos_x[15:0], pos_y[31:16], paint_red[32], paint_green[33],
	// shift_done[34], hold_refresh[35], zero[39:36]
	input  logic [39:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_axis_tuser,
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// row_bit[0], period_valid[1], timer_period[17:2], column_byte[25:18], zero[31:26]
	output logic [31:0] m_axis_tdata,
	// kind[1:0]
	output logic [1:0]  m_axis_tuser,
	// last
	output logic        m_axis_tlast
);

	localparam int PLANE_BYTES = ROWS * LINE_BYTES;
	localparam int STORE_BYTES = PLANES * PLANE_BYTES;
	localparam int HALF_LINE   = LINE_BYTES / 2;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int PW          = (PLANES > 1) ? $clog2(PLANES) : 1;
	localparam int IW          = $clog2(LINE_BYTES);
	localparam int YW          = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [7:0] LINE_AFTER_ZERO = (ROWS > 1) ? 8'd1 : 8'd0;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_PLOT_RD  = 3'd1;
	localparam logic [2:0] S_PLOT_WR  = 3'd2;
	localparam logic [2:0] S_TICK     = 3'd3;
	localparam logic [2:0] S_BYTE_OUT = 3'd4;

	// control state
	logic [2:0]             state_q, state_d;
	logic                   blank_done_q;
	logic [7:0]             line_q;
	logic [PW-1:0]          plane_q;
	logic                   out_vld_q;
	logic [15:0]            per_zero_q, per_one_q;
	logic                   draw_plane_q;
	logic [STORE_BYTES-1:0] vld_q;

	// payload registers
	logic [AW-1:0] addr_q, base_q;
	logic [IW-1:0] idx_q;
	logic [7:0]    bits_q;
	logic          red_q, green_q, pass_q;
	logic          shift_q, hold_q;
	logic          vld_rd_q;
	logic [1:0]    kind_q;
	logic          row_bit_q, pv_q, last_q;
	logic [15:0]   per_q;
	logic [7:0]    byte_q;

	// input word fields
	logic [15:0] pos_x, pos_y;
	logic        paint_red, paint_green, shift_done, hold_refresh;
	logic [1:0]  opcode;

	logic          in_acc, out_free, plot_ok;
	logic [AW-1:0] plot_addr;
	logic [7:0]    plot_bits;
	logic [7:0]    line_inc, line_nxt;
	logic          line_wrap;
	logic [PW-1:0] plane_nxt;
	logic [AW-1:0] base_nxt;
	logic [AW-1:0] add_a, add_b, addr_sum;
	logic [7:0]    store_byte;

	logic          ld, ld_row_bit, ld_pv, ld_last;
	logic [1:0]    ld_kind;
	logic [15:0]   ld_per;
	logic [7:0]    ld_byte;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    wr_data, rd_data;
	logic          tick_row, clear_now;

	assign pos_x        = s_axis_tdata[15:0];
	assign pos_y        = s_axis_tdata[31:16];
	assign paint_red    = s_axis_tdata[32];
	assign paint_green  = s_axis_tdata[33];
	assign shift_done   = s_axis_tdata[34];
	assign hold_refresh = s_axis_tdata[35];
	assign opcode       = s_axis_tuser;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'd0, byte_q, per_q, pv_q, row_bit_q};
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;

	// plot address and bit mask straight from the input word
	always_comb begin
		plot_ok = !pos_x[15] && (pos_x < 16'(COLUMNS))
			&& !pos_y[15] && (pos_y < 16'(ROWS))
			&& (32'(draw_plane_q) < 32'(PLANES))
			&& (32'(pos_x[15:3]) < 32'(HALF_LINE));
		plot_addr = AW'(int'(draw_plane_q) * PLANE_BYTES
			+ int'(pos_y[YW-1:0]) * LINE_BYTES + int'(pos_x[15:3]));
		plot_bits = 8'd1 << (3'(COLUMNS - 1) - pos_x[2:0]);
	end

	// line and plane step for a latch tick
	always_comb begin
		line_inc  = line_q + 8'd1;
		line_wrap = (line_inc >= 8'(ROWS));
		line_nxt  = line_wrap ? 8'd0 : line_inc;
		if (!line_wrap) begin
			plane_nxt = plane_q;
		end else if (plane_q == PW'(PLANES - 1)) begin
			plane_nxt = '0;
		end else begin
			plane_nxt = plane_q + PW'(1);
		end
		base_nxt = AW'(int'(plane_nxt) * PLANE_BYTES + int'(line_nxt) * LINE_BYTES);
	end

	// shared address adder
	always_comb begin
		case (state_q)
			S_TICK: begin
				add_a = base_nxt;
				add_b = AW'(LINE_BYTES - 1);
			end
			S_BYTE_OUT: begin
				add_a = base_q;
				add_b = AW'(idx_q - IW'(1));
			end
			default: begin
				add_a = addr_q;
				add_b = AW'(HALF_LINE);
			end
		endcase
		addr_sum = add_a + add_b;
	end

	assign store_byte = vld_rd_q ? rd_data : 8'd0;
	assign tick_row   = (state_q == S_TICK) && blank_done_q && !hold_q && shift_q
		&& out_free;

	// sequencer
	always_comb begin
		state_d    = state_q;
		ld         = 1'b0;
		ld_kind    = lmbs_pkg::KIND_BLANK;
		ld_row_bit = 1'b0;
		ld_pv      = 1'b0;
		ld_per     = 16'd0;
		ld_byte    = 8'd0;
		ld_last    = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = addr_sum;
		wr_en      = 1'b0;
		wr_data    = store_byte | bits_q;
		clear_now  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (opcode)
						lmbs_pkg::OP_PLOT: begin
							if (plot_ok && (paint_red || paint_green)) begin
								state_d = S_PLOT_RD;
							end
						end
						lmbs_pkg::OP_TICK:  state_d = S_TICK;
						lmbs_pkg::OP_CLEAR: clear_now = 1'b1;
						default: ;
					endcase
				end
			end
			S_PLOT_RD: begin
				rd_en   = 1'b1;
				rd_addr = addr_q;
				state_d = S_PLOT_WR;
			end
			S_PLOT_WR: begin
				wr_en = pass_q ? green_q : red_q;
				if (!pass_q && green_q) begin
					state_d = S_PLOT_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_TICK: begin
				if (!blank_done_q) begin
					if (out_free) begin
						ld      = 1'b1;
						ld_last = 1'b1;
						state_d = S_IDLE;
					end
				end else if (hold_q || !shift_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					ld         = 1'b1;
					ld_kind    = lmbs_pkg::KIND_ROW;
					ld_row_bit = (line_q != 8'd0);
					ld_pv      = (line_q == 8'd0);
					if (line_q == 8'd0) begin
						ld_per = (plane_q == '0) ? per_zero_q : per_one_q;
					end
					rd_en   = 1'b1;
					state_d = S_BYTE_OUT;
				end
			end
			S_BYTE_OUT: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_kind = lmbs_pkg::KIND_COLUMN;
					ld_byte = store_byte;
					ld_last = (idx_q == '0);
					if (idx_q == '0) begin
						state_d = S_IDLE;
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			blank_done_q <= 1'b1;
			line_q       <= lmbs_pkg::LINE_RST;
			plane_q      <= '0;
			out_vld_q    <= 1'b0;
			per_zero_q   <= lmbs_pkg::PERIOD_ZERO_RST;
			per_one_q    <= lmbs_pkg::PERIOD_ONE_RST;
			draw_plane_q <= lmbs_pkg::DRAW_PLANE_RST;
			vld_q        <= '0;
		end else begin
			state_q <= state_d;
			if (ld) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if (state_q == S_TICK && !blank_done_q && out_free) begin
				blank_done_q <= 1'b1;
			end else if (state_q == S_BYTE_OUT && out_free && idx_q == '0) begin
				blank_done_q <= 1'b0;
			end
			if (tick_row) begin
				line_q  <= line_nxt;
				plane_q <= plane_nxt;
			end
			if (clear_now) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[addr_q] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					lmbs_pkg::REG_PERIOD_ZERO: per_zero_q   <= cfg_data;
					lmbs_pkg::REG_PERIOD_ONE:  per_one_q    <= cfg_data;
					lmbs_pkg::REG_DRAW_PLANE:  draw_plane_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q  <= plot_addr;
			bits_q  <= plot_bits;
			red_q   <= paint_red;
			green_q <= paint_green;
			pass_q  <= 1'b0;
			shift_q <= shift_done;
			hold_q  <= hold_refresh;
		end else if (state_q == S_PLOT_WR && !pass_q) begin
			addr_q <= addr_sum;
			pass_q <= 1'b1;
		end
		if (tick_row) begin
			base_q <= base_nxt;
			idx_q  <= IW'(LINE_BYTES - 1);
		end else if (state_q == S_BYTE_OUT && out_free && idx_q != '0) begin
			idx_q <= idx_q - IW'(1);
		end
		if (rd_en) begin
			vld_rd_q <= vld_q[rd_addr];
		end
		if (ld) begin
			kind_q    <= ld_kind;
			row_bit_q <= ld_row_bit;
			pv_q      <= ld_pv;
			per_q     <= ld_per;
			byte_q    <= ld_byte;
			last_q    <= ld_last;
		end
	end

	lmbs_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_q),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// a period is only given on the row step that leaves line zero
	a_period_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && kind_q == lmbs_pkg::KIND_ROW && pv_q) |-> line_q == LINE_AFTER_ZERO)
		else $error("period word without a line-zero row step");

	// column bytes are only read once the line counter is in range
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BYTE_OUT) |-> (line_q < 8'(ROWS)))
		else $error("column read with line out of range");

	// the final column byte of a tick rearms the blanking phase
	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && kind_q == lmbs_pkg::KIND_COLUMN && last_q) |-> !blank_done_q)
		else $error("last column byte without pending blank");

	// a blank word always leaves the latch phase armed
	a_blank_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && kind_q == lmbs_pkg::KIND_BLANK) |-> blank_done_q)
		else $error("blank word with latch phase not armed");

endmodule

>>> rtl/core/lmbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are not reset.
module lmbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> test/testbench.sv
// Self-checking bench for led_matrix_bitplane_scanner_unit: random plot/tick/clear words
// go through a queue-fed driver, a scan predictor builds the expected result words.
// Depends on lmbs_pkg and the scanner unit RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PLANES      = lmbs_pkg::PLANES_DEF;
	localparam int COLUMNS     = lmbs_pkg::COLUMNS_DEF;
	localparam int ROWS        = lmbs_pkg::ROWS_DEF;
	localparam int LINE_BYTES  = lmbs_pkg::LINE_BYTES_DEF;
	localparam int PLANE_BYTES = ROWS * LINE_BYTES;
	localparam int STORE_BYTES = PLANES * PLANE_BYTES;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 40;
	localparam int CALM_LO     = 1500;
	localparam int CALM_HI     = 4500;
	localparam int PHASE_WORDS = 87;

	typedef struct {
		logic [1:0]  opcode;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic        paint_red;
		logic        paint_green;
		logic        shift_done;
		logic        hold_refresh;
	} scan_cmd_t;

	typedef struct {
		logic [1:0]  kind;
		logic        row_bit;
		logic        period_valid;
		logic [15:0] timer_period;
		logic [7:0]  column_byte;
		logic        last;
	} scan_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	led_matrix_bitplane_scanner_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// scanner state as predicted
	logic [7:0]  frame_mem [STORE_BYTES];
	logic        blank_done;
	logic [7:0]  line_cnt;
	int unsigned plane_cnt;
	logic [15:0] per_zero;
	logic [15:0] per_one;
	logic        draw_sel;

	scan_cmd_t   cmd_queue[$];
	scan_word_t  scan_due[$];
	scan_cmd_t   in_cur;
	logic        in_busy;
	scan_word_t  got_w;
	scan_word_t  want_w;
	int          err_cnt;
	int          cycle_cnt;
	logic        calm;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	assign calm = (cycle_cnt >= CALM_LO) && (cycle_cnt < CALM_HI);

	task automatic note_mismatch(input string field, input int unsigned got, input int unsigned want);
		$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
		err_cnt++;
	endtask

	function automatic void predict_scan(input scan_cmd_t c);
		int xi;
		int yi;
		int addr;
		int base;
		logic [7:0] mask;
		scan_word_t w;
		case (c.opcode)
			lmbs_pkg::OP_PLOT: begin
				xi = int'($signed(c.pos_x));
				yi = int'($signed(c.pos_y));
				if (xi >= 0 && xi < COLUMNS && yi >= 0 && yi < ROWS && draw_sel < PLANES
						&& (xi >> 3) < LINE_BYTES / 2) begin
					addr = draw_sel * PLANE_BYTES + yi * LINE_BYTES + (xi >> 3);
					mask = 8'd1 << ((COLUMNS - 1 - xi) & 7);
					if (c.paint_red)
						frame_mem[addr % STORE_BYTES] |= mask;
					if (c.paint_green)
						frame_mem[(addr + LINE_BYTES / 2) % STORE_BYTES] |= mask;
				end
			end
			lmbs_pkg::OP_TICK: begin
				if (!blank_done) begin
					w = '{lmbs_pkg::KIND_BLANK, 1'b0, 1'b0, 16'd0, 8'd0, 1'b1};
					scan_due.push_back(w);
					blank_done = 1'b1;
				end else if (!c.hold_refresh && c.shift_done) begin
					if (line_cnt == 8'd0)
						w = '{lmbs_pkg::KIND_ROW, 1'b0, 1'b1,
							(plane_cnt == 0) ? per_zero : per_one, 8'd0, 1'b0};
					else
						w = '{lmbs_pkg::KIND_ROW, 1'b1, 1'b0, 16'd0, 8'd0, 1'b0};
					scan_due.push_back(w);
					line_cnt = line_cnt + 8'd1;
					if (line_cnt >= ROWS) begin
						line_cnt = 8'd0;
						plane_cnt = (plane_cnt + 1) % PLANES;
					end
					base = plane_cnt * PLANE_BYTES + line_cnt * LINE_BYTES;
					// line goes out last byte first
					for (int i = LINE_BYTES - 1; i >= 0; i--) begin
						w = '{lmbs_pkg::KIND_COLUMN, 1'b0, 1'b0, 16'd0,
							frame_mem[(base + i) % STORE_BYTES], i == 0};
						scan_due.push_back(w);
					end
					blank_done = 1'b0;
				end
			end
			lmbs_pkg::OP_CLEAR: begin
				foreach (frame_mem[i])
					frame_mem[i] = 8'd0;
			end
			default: ;
		endcase
	endfunction

	function automatic scan_cmd_t mk_plot(input int x, input int y, input logic r, input logic g);
		scan_cmd_t c;
		c = '{lmbs_pkg::OP_PLOT, x[15:0], y[15:0], r, g, 1'b0, 1'b0};
		return c;
	endfunction

	function automatic scan_cmd_t mk_tick(input logic sd, input logic hold);
		scan_cmd_t c;
		c = '{lmbs_pkg::OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, sd, hold};
		return c;
	endfunction

	// mostly in-range plots and ticks; counts tells whether the word is a tick, a clear or an in-range plot
	function automatic scan_cmd_t rand_cmd(output logic counts);
		scan_cmd_t c;
		int pick;
		pick = $urandom_range(99);
		counts = 1'b1;
		c.opcode = lmbs_pkg::OP_TICK;
		c.pos_x = 16'($urandom);
		c.pos_y = 16'($urandom);
		c.paint_red = 1'($urandom_range(1));
		c.paint_green = 1'($urandom_range(1));
		c.shift_done = $urandom_range(99) >= 12;
		c.hold_refresh = $urandom_range(99) < 12;
		if (pick < 45) begin
			c.opcode = lmbs_pkg::OP_PLOT;
			c.pos_x = 16'($urandom_range(COLUMNS - 1));
			c.pos_y = 16'($urandom_range(ROWS - 1));
		end else if (pick < 53) begin
			c.opcode = lmbs_pkg::OP_PLOT;
			counts = 1'b0;
			if (pick < 49) begin
				// just off an edge of the matrix
				c.pos_x = $urandom_range(1) ? 16'hFFFF : 16'(COLUMNS);
				c.pos_y = 16'($urandom_range(ROWS - 1));
				if (pick < 47) begin
					c.pos_x = 16'($urandom_range(COLUMNS - 1));
					c.pos_y = $urandom_range(1) ? 16'hFFFF : 16'(ROWS);
				end
			end else if ((c.pos_x < COLUMNS) && (c.pos_y < ROWS)) begin
				counts = 1'b1;
			end
		end else if (pick >= 97) begin
			c.opcode = OP_UNUSED;
			counts = 1'b0;
		end else if (pick >= 95) begin
			c.opcode = lmbs_pkg::OP_CLEAR;
		end
		return c;
	endfunction

	task automatic write_regs(input logic [15:0] p0, input logic [15:0] p1, input logic dp);
		logic [1:0]  reg_ix [3];
		logic [15:0] reg_val [3];
		reg_ix = '{lmbs_pkg::REG_PERIOD_ZERO, lmbs_pkg::REG_PERIOD_ONE,
			lmbs_pkg::REG_DRAW_PLANE};
		reg_val = '{p0, p1, {15'd0, dp}};
		for (int i = 0; i < 3; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= reg_ix[i];
			cfg_data <= reg_val[i];
			do
				@(posedge clk);
			while (!cfg_ready);
			case (reg_ix[i])
				lmbs_pkg::REG_PERIOD_ZERO: per_zero = reg_val[i];
				lmbs_pkg::REG_PERIOD_ONE:  per_one = reg_val[i];
				lmbs_pkg::REG_DRAW_PLANE:  draw_sel = reg_val[i][0];
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_quiet();
		while (cmd_queue.size() != 0 || in_busy || scan_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_random(input int words);
		int n;
		scan_cmd_t c;
		logic counts;
		n = 0;
		while (n < words) begin
			c = rand_cmd(counts);
			cmd_queue.push_back(c);
			if (counts)
				n++;
		end
		wait_quiet();
	endtask

	// driver: next word goes out on the falling edge
	always @(negedge clk) begin
		if (arst_n && !in_busy) begin
			if (cmd_queue.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
				in_cur = cmd_queue.pop_front();
				in_busy = 1'b1;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {4'd0, in_cur.hold_refresh, in_cur.shift_done,
					in_cur.paint_green, in_cur.paint_red, in_cur.pos_y, in_cur.pos_x};
				s_axis_tuser <= in_cur.opcode;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		if (arst_n)
			m_axis_tready <= calm || ($urandom_range(99) >= 11);
	end

	// monitor: results checked before the accepted input is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_w = '{m_axis_tuser, m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[17:2],
					m_axis_tdata[25:18], m_axis_tlast};
				if (scan_due.size() == 0) begin
					note_mismatch("unexpected word", 32'(got_w.kind), 0);
				end else begin
					want_w = scan_due.pop_front();
					if (got_w.kind !== want_w.kind)
						note_mismatch("kind", 32'(got_w.kind), 32'(want_w.kind));
					if (got_w.row_bit !== want_w.row_bit)
						note_mismatch("row_bit", 32'(got_w.row_bit), 32'(want_w.row_bit));
					if (got_w.period_valid !== want_w.period_valid)
						note_mismatch("period_valid", 32'(got_w.period_valid),
							32'(want_w.period_valid));
					if (got_w.timer_period !== want_w.timer_period)
						note_mismatch("timer_period", 32'(got_w.timer_period),
							32'(want_w.timer_period));
					if (got_w.column_byte !== want_w.column_byte)
						note_mismatch("column_byte", 32'(got_w.column_byte),
							32'(want_w.column_byte));
					if (got_w.last !== want_w.last)
						note_mismatch("last", 32'(got_w.last), 32'(want_w.last));
				end
			end
			if (s_axis_tvalid && s_axis_tready && in_busy) begin
				predict_scan(in_cur);
				in_busy = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = lmbs_pkg::REG_PERIOD_ZERO;
		cfg_data = 16'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 40'd0;
		s_axis_tuser = lmbs_pkg::OP_PLOT;
		m_axis_tready = 1'b0;
		in_busy = 1'b0;
		err_cnt = 0;
		cycle_cnt = 0;
		foreach (frame_mem[i])
			frame_mem[i] = 8'd0;
		blank_done = 1'b1;
		line_cnt = lmbs_pkg::LINE_RST;
		plane_cnt = 0;
		per_zero = lmbs_pkg::PERIOD_ZERO_RST;
		per_one = lmbs_pkg::PERIOD_ONE_RST;
		draw_sel = lmbs_pkg::DRAW_PLANE_RST;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		write_regs(16'd0, 16'hFFFF, 1'b0);

		// matrix corners, off-edge plots, unused opcode, held and unfinished ticks
		cmd_queue.push_back(mk_plot(0, 0, 1'b1, 1'b1));
		cmd_queue.push_back(mk_plot(COLUMNS - 1, ROWS - 1, 1'b1, 1'b0));
		cmd_queue.push_back(mk_plot(COLUMNS - 1, 0, 1'b0, 1'b1));
		cmd_queue.push_back(mk_plot(5, 3, 1'b0, 1'b0));
		cmd_queue.push_back(mk_plot(-1, 0, 1'b1, 1'b1));
		cmd_queue.push_back(mk_plot(COLUMNS, 0, 1'b1, 1'b1));
		cmd_queue.push_back(mk_plot(0, -1, 1'b1, 1'b1));
		cmd_queue.push_back(mk_plot(0, ROWS, 1'b1, 1'b1));
		cmd_queue.push_back(mk_plot(-32768, 32767, 1'b1, 1'b1));
		cmd_queue.push_back(mk_plot(32767, -32768, 1'b1, 1'b1));
		cmd_queue.push_back(scan_cmd_t'{OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1});
		cmd_queue.push_back(mk_tick(1'b1, 1'b1));
		cmd_queue.push_back(mk_tick(1'b0, 1'b0));
		cmd_queue.push_back(mk_tick(1'b1, 1'b0));
		// blanking goes ahead even when held
		cmd_queue.push_back(mk_tick(1'b0, 1'b1));
		cmd_queue.push_back(mk_tick(1'b1, 1'b0));
		cmd_queue.push_back(mk_tick(1'b1, 1'b0));
		cmd_queue.push_back(scan_cmd_t'{lmbs_pkg::OP_CLEAR, 16'd0, 16'd0,
			1'b0, 1'b0, 1'b0, 1'b0});
		cmd_queue.push_back(mk_plot(8, 2, 1'b1, 1'b1));
		cmd_queue.push_back(mk_plot(15, 2, 1'b0, 1'b1));
		cmd_queue.push_back(mk_tick(1'b1, 1'b0));
		cmd_queue.push_back(mk_tick(1'b1, 1'b0));
		wait_quiet();

		run_random(PHASE_WORDS);
		write_regs(16'hFFFF, 16'd0, 1'b1);
		run_random(PHASE_WORDS);
		write_regs(16'($urandom), 16'($urandom), 1'b0);
		run_random(PHASE_WORDS);
		write_regs(16'($urandom), 16'($urandom), 1'b1);
		run_random(PHASE_WORDS);

		if (err_cnt == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
